/* rtl/hbrp_pkg.sv */
// shared types, constants and helper functions of the byte range parser
`default_nettype none

package hbrp_pkg;

  localparam int OFFSET_BITS   = 48;
  localparam int MAX_VALUE_LEN = 128;
  localparam int LEN_W         = $clog2(MAX_VALUE_LEN + 1);
  localparam int PREFIX_LEN    = 13;
  localparam int POS_W         = 4;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPP_A = 8'h41;
  localparam logic [7:0] CHAR_UPP_Z = 8'h5a;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  localparam logic [1:0] ST_FULL    = 2'd0;
  localparam logic [1:0] ST_PARTIAL = 2'd1;
  localparam logic [1:0] ST_UNSAT   = 2'd2;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef enum logic [2:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VSTART,
    PH_SUFFIX,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  typedef struct packed {
    logic    found;
    logic    err;
    logic    digits;
    phase_t  phase;
    offset_t first;
    offset_t second;
    offset_t size;
  } snap_t;

  // lower-case "range: bytes="
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h72;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h67;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h3a;
      4'd6:    c = 8'h20;
      4'd7:    c = 8'h62;
      4'd8:    c = 8'h79;
      4'd9:    c = 8'h74;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h73;
      4'd12:   c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // acc * 10 + d by shift-add, saturating at all ones
  function automatic offset_t add_digit(input offset_t acc, input logic [3:0] d);
    logic [OFFSET_BITS+3:0] w;
    w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{OFFSET_BITS{1'b0}}, d};
    if (|w[OFFSET_BITS+3:OFFSET_BITS]) begin
      return {OFFSET_BITS{1'b1}};
    end
    return w[OFFSET_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/hbrp_scan.sv */
// input register and per-byte header scanner with end-of-block snapshot
`default_nettype none

module hbrp_scan (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end,
  input  wire hbrp_pkg::offset_t in_size,
  output logic                  snap_valid,
  input  wire logic             snap_ready,
  output hbrp_pkg::snap_t       snap
);
  import hbrp_pkg::*;

  logic             s0_valid_r;
  logic [7:0]       s0_byte_r;
  logic             s0_end_r;
  offset_t          s0_size_r;
  logic             s0_go;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  offset_t          first_r, first_nxt;
  offset_t          second_r, second_nxt;
  logic             digits_r, digits_nxt;
  logic             err_r, err_nxt;
  logic             found_r, found_nxt;
  logic             closed_r, closed_nxt;

  logic             snap_valid_r;
  snap_t            snap_r;

  logic [7:0]       low;
  logic             is_digit;
  logic [3:0]       dig;
  offset_t          first_acc;
  offset_t          second_acc;

  assign s0_go    = s0_valid_r && (!s0_end_r || snap_ready);
  assign in_ready = !s0_valid_r || s0_go;

  assign low        = (s0_byte_r >= CHAR_UPP_A && s0_byte_r <= CHAR_UPP_Z) ?
                      s0_byte_r + CASE_DELTA : s0_byte_r;
  assign is_digit   = (s0_byte_r >= CHAR_ZERO) && (s0_byte_r <= CHAR_NINE);
  assign dig        = s0_byte_r[3:0];
  assign first_acc  = add_digit(first_r, dig);
  assign second_acc = add_digit(second_r, dig);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    digits_nxt = digits_r;
    err_nxt    = err_r;
    found_nxt  = found_r;
    closed_nxt = closed_r;
    if (found_r) begin
      if (!closed_r) begin
        if (s0_byte_r == CHAR_CR || s0_byte_r == CHAR_LF || s0_byte_r == CHAR_NUL) begin
          closed_nxt = 1'b1;
        end else begin
          if (len_r < LEN_W'(MAX_VALUE_LEN)) begin
            len_nxt = len_r + 1'b1;
          end
          if (len_nxt >= LEN_W'(MAX_VALUE_LEN)) begin
            err_nxt = 1'b1;
          end
          if (!err_nxt) begin
            unique case (phase_r)
              PH_VSTART: begin
                if (s0_byte_r == CHAR_DASH) begin
                  phase_nxt = PH_SUFFIX;
                end else if (is_digit) begin
                  phase_nxt  = PH_FIRST;
                  first_nxt  = {{(OFFSET_BITS-4){1'b0}}, dig};
                  digits_nxt = 1'b1;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              PH_SUFFIX: begin
                if (is_digit) begin
                  first_nxt  = first_acc;
                  digits_nxt = 1'b1;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              PH_FIRST: begin
                if (is_digit) begin
                  first_nxt = first_acc;
                end else if (s0_byte_r == CHAR_DASH) begin
                  phase_nxt  = PH_SECOND;
                  digits_nxt = 1'b0;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              PH_SECOND: begin
                if (is_digit) begin
                  second_nxt = second_acc;
                  digits_nxt = 1'b1;
                end else begin
                  err_nxt = 1'b1;
                end
              end
              default: err_nxt = 1'b1;
            endcase
          end
        end
      end
    end else if (s0_byte_r == CHAR_LF) begin
      phase_nxt = PH_MATCH;
      pos_nxt   = '0;
    end else if (phase_r == PH_MATCH) begin
      if (low == prefix_char(pos_r)) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == POS_W'(PREFIX_LEN - 1)) begin
          found_nxt = 1'b1;
          phase_nxt = PH_VSTART;
        end
      end else begin
        phase_nxt = PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      snap_valid_r <= 1'b0;
      phase_r      <= PH_MATCH;
      pos_r        <= '0;
      len_r        <= '0;
      first_r      <= '0;
      second_r     <= '0;
      digits_r     <= 1'b0;
      err_r        <= 1'b0;
      found_r      <= 1'b0;
      closed_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (snap_ready) begin
        snap_valid_r <= s0_go && s0_end_r;
      end
      if (s0_go) begin
        if (s0_end_r) begin
          phase_r  <= PH_MATCH;
          pos_r    <= '0;
          len_r    <= '0;
          first_r  <= '0;
          second_r <= '0;
          digits_r <= 1'b0;
          err_r    <= 1'b0;
          found_r  <= 1'b0;
          closed_r <= 1'b0;
        end else begin
          phase_r  <= phase_nxt;
          pos_r    <= pos_nxt;
          len_r    <= len_nxt;
          first_r  <= first_nxt;
          second_r <= second_nxt;
          digits_r <= digits_nxt;
          err_r    <= err_nxt;
          found_r  <= found_nxt;
          closed_r <= closed_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_byte_r <= in_byte;
      s0_end_r  <= in_end;
      s0_size_r <= in_size;
    end
    if (s0_go && s0_end_r) begin
      snap_r.found  <= found_nxt;
      snap_r.err    <= err_nxt;
      snap_r.digits <= digits_nxt;
      snap_r.phase  <= phase_nxt;
      snap_r.first  <= first_nxt;
      snap_r.second <= second_nxt;
      snap_r.size   <= s0_size_r;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

/* rtl/hbrp_resolve.sv */
// range check, clamping and output register
`default_nettype none

module hbrp_resolve (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              snap_valid,
  output logic                   snap_ready,
  input  wire hbrp_pkg::snap_t   snap,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output hbrp_pkg::offset_t      out_start,
  output hbrp_pkg::offset_t      out_end
);
  import hbrp_pkg::*;

  logic       out_valid_r;
  logic [1:0] status_r;
  offset_t    start_r;
  offset_t    end_r;

  logic       slot_free;
  logic [1:0] status_c;
  offset_t    start_c;
  offset_t    end_c;
  offset_t    size_m1;
  offset_t    size_minus_first;
  logic       size_zero;
  logic       first_ge_size;
  logic       second_lt_first;
  logic       second_ge_size;

  assign slot_free  = !out_valid_r || out_ready;
  assign snap_ready = slot_free;

  assign size_zero        = (snap.size == '0);
  assign size_m1          = snap.size - 1'b1;
  assign size_minus_first = snap.size - snap.first;
  assign first_ge_size    = (snap.first >= snap.size);
  assign second_lt_first  = (snap.second < snap.first);
  assign second_ge_size   = (snap.second >= snap.size);

  always_comb begin
    status_c = ST_UNSAT;
    start_c  = '0;
    end_c    = '0;
    if (!snap.found) begin
      status_c = ST_FULL;
      end_c    = size_zero ? '0 : size_m1;
    end else if (!snap.err && !size_zero) begin
      if (snap.phase == PH_SUFFIX) begin
        if (snap.digits && snap.first != '0) begin
          status_c = ST_PARTIAL;
          start_c  = first_ge_size ? '0 : size_minus_first;
          end_c    = size_m1;
        end
      end else if (snap.phase == PH_SECOND) begin
        if (!(snap.digits && second_lt_first) && !first_ge_size) begin
          status_c = ST_PARTIAL;
          start_c  = snap.first;
          end_c    = (snap.digits && !second_ge_size) ? snap.second : size_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && snap_valid) begin
      status_r <= status_c;
      start_r  <= start_c;
      end_r    <= end_c;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_start  = start_r;
  assign out_end    = end_r;

endmodule

`default_nettype wire

/* rtl/http_byte_range_parser_unit.sv */
// top level of the http byte range parser
//
// Takes one header byte per cycle unless the result channel stalls, and finds
// the first line that begins with "Range: bytes=" (any case), parsing a
// single suffix, closed or open range. One result transaction is produced
// for each block, after the byte marked with tlast: status 0 is the full
// file, 1 a partial range, 2 not satisfiable. After the final byte is
// accepted, the result passes the input register, scanner snapshot and output
// register. The only stall source is the result channel: a finished result
// waits in the output register while the next block's bytes keep flowing in.
`default_nettype none

module http_byte_range_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,   // header_byte[7:0], file_size[55:8]
  input  wire logic         in_tlast,   // block_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // range_start[47:0], range_end[95:48]
  output logic [1:0]        out_tuser   // range_status
);
  import hbrp_pkg::*;

  logic    snap_valid;
  logic    snap_ready;
  snap_t   snap;
  offset_t range_start;
  offset_t range_end;

  hbrp_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata[7:0]),
    .in_end     (in_tlast),
    .in_size    (in_tdata[55:8]),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  hbrp_resolve u_resolve (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_start  (range_start),
    .out_end    (range_end)
  );

  assign out_tdata = {range_end, range_start};

endmodule

`default_nettype wire
